FILE: rtl/trwr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC readout word reformatter package
// Shared types, word type codes and sizing constants for the reformatter.
// ============================================================================
package trwr_pkg;

    // Event sizing.
    localparam int unsigned MAX_EVENT_WORDS = 131072;
    localparam int unsigned TPOS_W          = 17;
    localparam int unsigned POS_LIMIT       = 2 ** TPOS_W;
    localparam int unsigned WORD_LIMIT      =
        (MAX_EVENT_WORDS < POS_LIMIT) ? MAX_EVENT_WORDS : POS_LIMIT;
    // The output position must be able to hold the limit itself.
    localparam int unsigned OPOS_W          = $clog2(WORD_LIMIT + 1);

    // Expected slot table.
    localparam int unsigned SLOT_TABLE_SIZE = 22;
    localparam int unsigned SLOT_W          = 5;
    localparam int unsigned SLOTS_LOW_W     = 60;
    localparam int unsigned SLOTS_HIGH_W    = 50;
    localparam int unsigned SLOTS_W         = SLOTS_LOW_W + SLOTS_HIGH_W;
    localparam logic [SLOT_W-1:0] HS_MAX    = '1;

    // Counter widths.
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned TCNT_W  = 14;

    // Header restart values of the counts.
    localparam logic [CNT_W-1:0] HDR_DATA_INIT = 16'd1;
    localparam logic [CNT_W-1:0] HDR_SUB_INIT  = 16'd9;

    // Word type codes in bits 31:27.
    localparam logic [4:0] TYPE_DATA  = 5'h00;
    localparam logic [4:0] TYPE_ERR   = 5'h04;
    localparam logic [4:0] TYPE_GHDR  = 5'h08;
    localparam logic [4:0] TYPE_GTRL  = 5'h10;
    localparam logic [4:0] TYPE_TTAG  = 5'h11;

    // Configuration register indexes (byte address bits 4:3).
    localparam int unsigned PADDR_W = 5;
    localparam logic [1:0] REG_SWAP       = 2'd0;
    localparam logic [1:0] REG_SLOT_FIX   = 2'd1;
    localparam logic [1:0] REG_SLOTS_LOW  = 2'd2;
    localparam logic [1:0] REG_SLOTS_HIGH = 2'd3;

    // Output queue between front and back.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // Classified operation of one word.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DATA,
        OP_SUB,
        OP_HDR,
        OP_TRL
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        event_start;
        logic [31:0] word;
    } t_q_item;

    typedef struct packed {
        logic    valid;
        t_q_item item;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic               swap_bytes;
        logic               slot_fix_enable;
        logic [SLOTS_W-1:0] slots;
    } t_cfg;

endpackage

FILE: rtl/trwr_if.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC reformatter channel interfaces
// Valid/ready channels for raw input words and reformatted result words.
// ============================================================================
interface trwr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_word;
    logic        event_start;

    modport source (output valid, output raw_word, output event_start, input ready);
    modport sink   (input valid, input raw_word, input event_start, output ready);
endinterface

interface trwr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic        kind;
    logic [16:0] target_position;
    logic        count_mismatch;
    logic        slot_corrected;

    modport source (output valid, output out_word, output kind, output target_position,
                    output count_mismatch, output slot_corrected, input ready);
    modport sink   (input valid, input out_word, input kind, input target_position,
                    input count_mismatch, input slot_corrected, output ready);
endinterface

FILE: rtl/tdc_readout_word_reformatter.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC readout word reformatter
// Reformats multi-hit TDC readout words into event words and header patches.
// ============================================================================
// Usage:
//   i_in carries one raw 32-bit readout word per transfer, with event_start
//   set on the first word of an event. o_out carries result words: kind 0
//   appends out_word at target_position, kind 1 ORs out_word into the header
//   word already written at target_position. Data and header words produce
//   an append, global trailers a patch; other word types produce nothing.
//   The APB port sets byte swap, slot correction and the expected slots;
//   the user must write it only while no word is in flight: the block does
//   not enforce this. Words pass the queue and then the output register.
//   One word is taken per cycle while the queue has room.
//   A two-entry queue and the output register let the input keep flowing
//   while the receiver stalls; i_in.ready falls only once both are full.
//   Reset clears all counts, the slot, the queue and the output register,
//   and loads swap and slot fix enabled with an all-zero slot table.
// ============================================================================
module tdc_readout_word_reformatter
    import trwr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    trwr_in_if.sink            i_in,
    trwr_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    t_cfg    cfg;
    t_push   push;
    t_q_item q_item;
    t_q_stat q_stat;
    logic    pop;

    // Configuration registers.
    trwr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Classifier.
    trwr_front u_front (
        .i_in         (i_in),
        .i_swap_bytes (cfg.swap_bytes),
        .i_q_stat     (q_stat),
        .o_push       (push)
    );

    // Queue between the two halves.
    trwr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // State engine and output register.
    trwr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (q_item),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // A classified word is never pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> !q_stat.full)
        else $error("word pushed into full queue");

    // Patches never carry a slot correction; appends never flag a mismatch.
    a_flag_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.kind && o_out.slot_corrected) &&
                        !(!o_out.kind && o_out.count_mismatch))
        else $error("result flag does not match its kind");

    // Nothing is shown on the output right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid after reset");

    // The back end only consumes when the queue holds a word.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

FILE: rtl/trwr_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC reformatter configuration registers
// APB-style register file holding byte swap, slot fix and expected slots.
// ============================================================================
module trwr_regs
    import trwr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic                    r_swap;
    logic                    r_fix;
    logic [SLOTS_LOW_W-1:0]  r_slots_low;
    logic [SLOTS_HIGH_W-1:0] r_slots_high;
    logic                    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap       <= 1'b1;
            r_fix        <= 1'b1;
            r_slots_low  <= '0;
            r_slots_high <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:3])
                REG_SWAP:       r_swap       <= pwdata[0];
                REG_SLOT_FIX:   r_fix        <= pwdata[0];
                REG_SLOTS_LOW:  r_slots_low  <= pwdata[SLOTS_LOW_W-1:0];
                REG_SLOTS_HIGH: r_slots_high <= pwdata[SLOTS_HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (paddr[4:3])
            REG_SWAP:       prdata = {63'd0, r_swap};
            REG_SLOT_FIX:   prdata = {63'd0, r_fix};
            REG_SLOTS_LOW:  prdata = {{(64-SLOTS_LOW_W){1'b0}}, r_slots_low};
            REG_SLOTS_HIGH: prdata = {{(64-SLOTS_HIGH_W){1'b0}}, r_slots_high};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.swap_bytes      = r_swap;
    assign o_cfg.slot_fix_enable = r_fix;
    assign o_cfg.slots           = {r_slots_high, r_slots_low};

endmodule

FILE: rtl/trwr_front.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC reformatter front end
// Accepts raw words, applies the byte swap and classifies the word type.
// ============================================================================
module trwr_front
    import trwr_pkg::*;
(
    trwr_in_if.sink i_in,
    input  logic    i_swap_bytes,
    input  t_q_stat i_q_stat,
    output t_push   o_push
);

    logic [31:0] word;
    t_op         op;

    // Accept a word whenever the queue has room.
    assign i_in.ready = ~i_q_stat.full;

    // Optional byte reversal.
    assign word = i_swap_bytes ?
        {i_in.raw_word[7:0], i_in.raw_word[15:8], i_in.raw_word[23:16], i_in.raw_word[31:24]} :
        i_in.raw_word;

    // Type decode.
    always_comb begin
        unique case (word[31:27]) inside
            TYPE_DATA:           op = OP_DATA;
            TYPE_TTAG, TYPE_ERR: op = OP_SUB;
            TYPE_GHDR:           op = OP_HDR;
            TYPE_GTRL:           op = OP_TRL;
            default:             op = OP_NONE;
        endcase
    end

    // Words that neither change state nor clear it are dropped here.
    assign o_push.valid            = i_in.valid & i_in.ready &
                                     ((op != OP_NONE) | i_in.event_start);
    assign o_push.item.op          = op;
    assign o_push.item.event_start = i_in.event_start;
    assign o_push.item.word        = word;

endmodule

FILE: rtl/trwr_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC reformatter word queue
// Small register queue decoupling the classifier from the state engine.
// ============================================================================
module trwr_fifo
    import trwr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_q_item o_item,
    output t_q_stat o_stat
);

    t_q_item          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr;
    logic [Q_AW-1:0]  r_rptr;
    logic [Q_CW-1:0]  r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push.valid & ~o_stat.full;
    assign do_pop       = i_pop & ~o_stat.empty;
    assign o_item       = r_mem[r_rptr];

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/trwr_back.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC reformatter back end
// Keeps the event counts and slot, and builds append and patch words.
// ============================================================================
module trwr_back
    import trwr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_q_item     i_item,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    trwr_out_if.source  o_out
);

    // Event state.
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_dc, n_dc;
    logic [CNT_W-1:0]  r_sub, n_sub;
    logic [TPOS_W-1:0] r_hpos, n_hpos;
    logic [OPOS_W-1:0] r_opos, n_opos;
    logic [SLOT_W-1:0] r_hs, n_hs;

    // Output register.
    logic              r_valid;
    logic [31:0]       r_word, n_word;
    logic              r_kind, n_kind;
    logic [TPOS_W-1:0] r_pos, n_pos;
    logic              r_mism, n_mism;
    logic              r_corr, n_corr;
    logic              n_emit;

    // State as seen by this word, after an optional event clear.
    logic [SLOT_W-1:0] c_slot;
    logic [CNT_W-1:0]  c_dc;
    logic [CNT_W-1:0]  c_sub;
    logic [TPOS_W-1:0] c_hpos;
    logic [OPOS_W-1:0] c_opos;
    logic [SLOT_W-1:0] c_hs;

    logic              room;
    logic              idx_ok;
    logic [SLOT_W-1:0] hs_sel;
    logic [SLOT_W-1:0] exp_slot;
    logic [CNT_W:0]    diff;

    // Take the next word when the output register is free or draining.
    assign o_pop = ~i_q_stat.empty & (~r_valid | o_out.ready);

    assign c_slot = i_item.event_start ? '0 : r_slot;
    assign c_dc   = i_item.event_start ? '0 : r_dc;
    assign c_sub  = i_item.event_start ? '0 : r_sub;
    assign c_hpos = i_item.event_start ? '0 : r_hpos;
    assign c_opos = i_item.event_start ? '0 : r_opos;
    assign c_hs   = i_item.event_start ? '0 : r_hs;

    assign room     = (c_opos < OPOS_W'(WORD_LIMIT));
    assign idx_ok   = (c_hs < SLOT_W'(SLOT_TABLE_SIZE)) & i_cfg.slot_fix_enable;
    assign hs_sel   = idx_ok ? c_hs : '0;
    assign exp_slot = i_cfg.slots[SLOT_W*hs_sel +: SLOT_W];

    // Trailer count minus subtract count; the top bit marks a wrap.
    assign diff = {{(CNT_W-TCNT_W+1){1'b0}}, i_item.word[18:5]} - {1'b0, c_sub};

    // Word execution.
    always_comb begin
        n_slot = c_slot;
        n_dc   = c_dc;
        n_sub  = c_sub;
        n_hpos = c_hpos;
        n_opos = c_opos;
        n_hs   = c_hs;
        n_emit = 1'b0;
        n_word = i_item.word;
        n_kind = 1'b0;
        n_pos  = c_opos[TPOS_W-1:0];
        n_mism = 1'b0;
        n_corr = 1'b0;
        unique case (i_item.op)
            OP_DATA: begin
                n_dc   = c_dc + 1'b1;
                n_word = {c_slot, i_item.word[26:0]};
                n_emit = room;
            end
            OP_SUB: begin
                n_sub = c_sub + 1'b1;
            end
            OP_HDR: begin
                n_dc   = HDR_DATA_INIT;
                n_sub  = HDR_SUB_INIT;
                n_hpos = c_opos[TPOS_W-1:0];
                if (idx_ok && (exp_slot != i_item.word[SLOT_W-1:0])) begin
                    n_slot = exp_slot;
                    n_corr = 1'b1;
                end else begin
                    n_slot = i_item.word[SLOT_W-1:0];
                end
                if (c_hs != HS_MAX) begin
                    n_hs = c_hs + 1'b1;
                end
                n_word = {{(32-SLOT_W){1'b0}}, n_slot};
                n_emit = room;
            end
            OP_TRL: begin
                n_word = {{(32-CNT_W-6){diff[CNT_W]}}, diff, 5'd0};
                n_kind = 1'b1;
                n_pos  = c_hpos;
                n_mism = diff[CNT_W] | (diff[CNT_W-1:0] != c_dc);
                n_emit = 1'b1;
            end
            default: ;
        endcase
        if (n_emit && !n_kind) begin
            n_opos = c_opos + 1'b1;
        end
    end

    // State and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_dc    <= '0;
            r_sub   <= '0;
            r_hpos  <= '0;
            r_opos  <= '0;
            r_hs    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_slot  <= n_slot;
                r_dc    <= n_dc;
                r_sub   <= n_sub;
                r_hpos  <= n_hpos;
                r_opos  <= n_opos;
                r_hs    <= n_hs;
                r_valid <= n_emit;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) begin
            r_word <= n_word;
            r_kind <= n_kind;
            r_pos  <= n_pos;
            r_mism <= n_mism;
            r_corr <= n_corr;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.out_word        = r_word;
    assign o_out.kind            = r_kind;
    assign o_out.target_position = r_pos;
    assign o_out.count_mismatch  = r_mism;
    assign o_out.slot_corrected  = r_corr;

endmodule

FILE: dv/trwr_result_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC readout word reformatter result checker
// Watches the word channels and the APB port of the reformatter, predicts
// every result word from the accepted input words and compares each result
// field by field, in order. Register read data is compared as well.
// ============================================================================
module trwr_result_checker
    import trwr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    trwr_in_if                 i_in,
    trwr_out_if                i_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [63:0]        i_pwdata,
    input  logic [63:0]        i_prdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    // Appends are dropped once the event reaches this many output words.
    localparam int unsigned EVENT_LIMIT =
        (MAX_EVENT_WORDS < 131072) ? MAX_EVENT_WORDS : 131072;
    localparam logic [15:0] HEADER_DATA_START = 16'd1;
    localparam logic [15:0] HEADER_SUB_START  = 16'd9;
    localparam logic [4:0]  HEADER_COUNT_MAX  = 5'h1F;
    localparam logic        KIND_APPEND       = 1'b0;
    localparam logic        KIND_PATCH        = 1'b1;
    localparam int unsigned PRINT_LIMIT       = 30;

    typedef struct packed {
        logic [31:0] out_word;
        logic        kind;
        logic [16:0] target_position;
        logic        count_mismatch;
        logic        slot_corrected;
    } t_result;

    t_result     expected_words[$];
    int          fail_count;
    int unsigned words_checked;

    // Register copy.
    logic        cfg_swap;
    logic        cfg_fix;
    logic [59:0] cfg_slots_low;
    logic [49:0] cfg_slots_high;

    // Event state.
    logic [4:0]  board_slot;
    logic [15:0] data_count;
    logic [15:0] subtract_count;
    logic [16:0] header_position;
    logic [17:0] out_position;
    logic [4:0]  headers_seen;

    task automatic report_error(input string what);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("word %0d %s got %0h expected %0h",
                                   words_checked, name, got, want));
        end
    endtask

    task automatic clear_counts();
        board_slot      = '0;
        data_count      = '0;
        subtract_count  = '0;
        header_position = '0;
        out_position    = '0;
        headers_seen    = '0;
    endtask

    // Decode one accepted word and queue the result it causes, if any.
    task automatic reformat_word(input logic [31:0] raw, input logic start);
        logic [31:0]  w;
        logic [31:0]  diff;
        logic [4:0]   slot;
        logic [4:0]   table_entry;
        logic [109:0] slot_table;
        logic         corr;
        t_result      r;
        if (start) begin
            clear_counts();
        end
        w = cfg_swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
        r = '0;
        case (w[31:27])
            TYPE_DATA: begin
                data_count = data_count + 16'd1;
                if (out_position < EVENT_LIMIT) begin
                    r.out_word        = w | {board_slot, 27'd0};
                    r.kind            = KIND_APPEND;
                    r.target_position = out_position[16:0];
                    expected_words.push_back(r);
                    out_position++;
                end
            end
            TYPE_TTAG, TYPE_ERR: begin
                subtract_count = subtract_count + 16'd1;
            end
            TYPE_GHDR: begin
                slot            = w[4:0];
                corr            = 1'b0;
                data_count      = HEADER_DATA_START;
                subtract_count  = HEADER_SUB_START;
                header_position = out_position[16:0];
                // Only the first headers of an event have a table entry.
                if (headers_seen < SLOT_TABLE_SIZE && cfg_fix) begin
                    slot_table  = {cfg_slots_high, cfg_slots_low};
                    table_entry = slot_table[headers_seen * 5 +: 5];
                    if (table_entry != slot) begin
                        slot = table_entry;
                        corr = 1'b1;
                    end
                end
                board_slot = slot;
                if (headers_seen != HEADER_COUNT_MAX) begin
                    headers_seen++;
                end
                if (out_position < EVENT_LIMIT) begin
                    r.out_word        = {27'd0, slot};
                    r.kind            = KIND_APPEND;
                    r.target_position = out_position[16:0];
                    r.slot_corrected  = corr;
                    expected_words.push_back(r);
                    out_position++;
                end
            end
            TYPE_GTRL: begin
                // The difference wraps at 32 bits before the shift.
                diff              = {18'd0, w[18:5]} - {16'd0, subtract_count};
                r.out_word        = diff << 5;
                r.kind            = KIND_PATCH;
                r.target_position = header_position;
                r.count_mismatch  = (diff != {16'd0, data_count});
                expected_words.push_back(r);
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        fail_count    = 0;
        words_checked = 0;
    end

    always @(posedge i_clk) begin
        t_result     want;
        logic [63:0] reg_value;
        if (!i_rst_n) begin
            cfg_swap       = 1'b1;
            cfg_fix        = 1'b1;
            cfg_slots_low  = '0;
            cfg_slots_high = '0;
            clear_counts();
            expected_words.delete();
        end else begin
            // Results always leave after their input word, since each passes the queue and the output register.
            if (i_out.valid && i_out.ready) begin
                if (expected_words.size() == 0) begin
                    report_error($sformatf("result word %0h with nothing expected",
                                           i_out.out_word));
                end else begin
                    want = expected_words.pop_front();
                    compare_field("out_word", 64'(i_out.out_word), 64'(want.out_word));
                    compare_field("kind", 64'(i_out.kind), 64'(want.kind));
                    compare_field("target_position", 64'(i_out.target_position),
                                  64'(want.target_position));
                    compare_field("count_mismatch", 64'(i_out.count_mismatch),
                                  64'(want.count_mismatch));
                    compare_field("slot_corrected", 64'(i_out.slot_corrected),
                                  64'(want.slot_corrected));
                end
                words_checked++;
            end
            if (i_in.valid && i_in.ready) begin
                reformat_word(i_in.raw_word, i_in.event_start);
            end
            // Register access phase.
            if (i_psel && i_penable && i_pready) begin
                case (i_paddr[4:3])
                    REG_SWAP:      reg_value = {63'd0, cfg_swap};
                    REG_SLOT_FIX:  reg_value = {63'd0, cfg_fix};
                    REG_SLOTS_LOW: reg_value = {4'd0, cfg_slots_low};
                    default:       reg_value = {14'd0, cfg_slots_high};
                endcase
                if (i_pwrite) begin
                    case (i_paddr[4:3])
                        REG_SWAP:      cfg_swap       = i_pwdata[0];
                        REG_SLOT_FIX:  cfg_fix        = i_pwdata[0];
                        REG_SLOTS_LOW: cfg_slots_low  = i_pwdata[59:0];
                        default:       cfg_slots_high = i_pwdata[49:0];
                    endcase
                end else if (i_prdata !== reg_value) begin
                    report_error($sformatf("register %0d read %0h expected %0h",
                                           i_paddr[4:3], i_prdata, reg_value));
                end
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// TDC readout word reformatter testbench
// Drives directed and random readout streams (well-formed multi-board events,
// broken events and noise) through the reformatter under several register
// settings, with bursty input and a stalling receiver. A separate checker
// predicts and compares every result word.
// ============================================================================
module tb_top;
    import trwr_pkg::*;

    localparam logic [4:0]  TYPE_TDC_HDR   = 5'h01;
    localparam logic [4:0]  TYPE_TDC_TRL   = 5'h03;
    localparam logic [4:0]  TYPE_FILLER    = 5'h18;
    localparam int unsigned ITEM_TARGET    = 1650;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    trwr_in_if  in_if ();
    trwr_out_if out_if ();

    // Stimulus bookkeeping.
    logic         swap_on;
    logic [109:0] slot_mirror;
    logic         start_pending;
    int unsigned  items_sent;
    int unsigned  burst_left;

    tdc_readout_word_reformatter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    trwr_result_checker u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [26:0] rand27();
        logic [31:0] r;
        r = $urandom;
        return r[26:0];
    endfunction

    // Offer one raw word; bursts end with a random gap.
    task automatic send_raw(input logic [31:0] raw, input logic start);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_if.valid       <= 1'b1;
        in_if.raw_word    <= raw;
        in_if.event_start <= start;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Send a decoded word as the board would put it on the bus.
    task automatic send_word(input logic [31:0] w);
        send_raw(swap_on ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w, start_pending);
        start_pending = 1'b0;
    endtask

    // Stop sending and wait until every result word has come out.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write every register, with junk in the unused bits, then read all back.
    task automatic set_config(input logic sw, input logic fix, input logic [63:0] low,
                              input logic [63:0] high);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        apb_access(1'b1, REG_SWAP, {junk[63:1], sw});
        apb_access(1'b1, REG_SLOT_FIX, {junk[62:0], fix});
        apb_access(1'b1, REG_SLOTS_LOW, low);
        apb_access(1'b1, REG_SLOTS_HIGH, high);
        apb_access(1'b0, REG_SWAP, '0);
        apb_access(1'b0, REG_SLOT_FIX, '0);
        apb_access(1'b0, REG_SLOTS_LOW, '0);
        apb_access(1'b0, REG_SLOTS_HIGH, '0);
        swap_on     = sw;
        slot_mirror = {high[49:0], low[59:0]};
    endtask

    // One event: mostly well-formed boards, sometimes broken or plain noise.
    task automatic send_event();
        int unsigned shape;
        int unsigned boards;
        int unsigned chips;
        int unsigned hits;
        logic        big;
        logic [15:0] dc;
        logic [15:0] sc;
        logic [13:0] n;
        logic [31:0] hdr;
        logic [31:0] junk;
        shape = $urandom_range(0, 99);
        if (shape < 12) begin
            repeat ($urandom_range(1, 8)) send_raw($urandom, $urandom_range(0, 7) == 0);
        end else begin
            big           = ($urandom_range(0, 11) == 0);
            boards        = big ? $urandom_range(20, 36) : $urandom_range(1, 3);
            start_pending = 1'b1;
            for (int b = 0; b < boards; b++) begin
                dc = 16'd1;
                sc = 16'd9;
                // Broken event: the first board has lost its global header.
                if (!(shape < 20 && b == 0)) begin
                    hdr = {TYPE_GHDR, rand27()};
                    if (b < SLOT_TABLE_SIZE && $urandom_range(0, 1) == 1) begin
                        hdr[4:0] = slot_mirror[b * 5 +: 5];
                    end
                    send_word(hdr);
                end
                chips = big ? $urandom_range(0, 1) : $urandom_range(1, 4);
                repeat (chips) begin
                    send_word({TYPE_TDC_HDR, rand27()});
                    hits = big ? $urandom_range(0, 2) : $urandom_range(0, 8);
                    repeat (hits) begin
                        send_word({TYPE_DATA, rand27()});
                        dc++;
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        send_word({TYPE_ERR, rand27()});
                        sc++;
                    end
                    send_word({TYPE_TDC_TRL, rand27()});
                end
                if ($urandom_range(0, 1) == 1) begin
                    send_word({TYPE_TTAG, rand27()});
                    sc++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_word({TYPE_FILLER, rand27()});
                end
                // Broken event: the last board has lost its global trailer.
                if (!(shape >= 20 && shape < 25 && b == boards - 1)) begin
                    junk = $urandom;
                    n    = ($urandom_range(0, 3) == 0) ? junk[13:0] : 14'(dc + sc);
                    junk = $urandom;
                    send_word({TYPE_GTRL, junk[7:0], n, junk[12:8]});
                end
            end
        end
    endtask

    // Receiver: switches between random stall patterns.
    initial begin : receiver
        t_rx_mode    mode;
        int unsigned left;
        int unsigned tick;
        out_if.ready = 1'b0;
        mode = RX_FLOW;
        left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 300);
            end
            left--;
            tick++;
            case (mode)
                RX_FLOW:  out_if.ready <= 1'b1;
                RX_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: out_if.ready <= ($urandom_range(0, 3) == 0);
                default:  out_if.ready <= ((tick % 16) < 11);
            endcase
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus.
    initial begin
        int unsigned phase_end;
        int unsigned pause_at;
        logic        paused;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.raw_word    = '0;
        in_if.event_start = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        swap_on           = 1'b1;
        slot_mirror       = '0;
        start_pending     = 1'b0;
        items_sent        = 0;
        burst_left        = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the registers.
        apb_access(1'b0, REG_SWAP, '0);
        apb_access(1'b0, REG_SLOT_FIX, '0);
        apb_access(1'b0, REG_SLOTS_LOW, '0);
        apb_access(1'b0, REG_SLOTS_HIGH, '0);

        // Directed: trailer before any header patches position zero.
        send_word({TYPE_GTRL, 8'h00, 14'd5, 5'h00});
        // Header with slot 31 against an all-zero table is corrected.
        start_pending = 1'b1;
        send_word({TYPE_GHDR, 27'h7FF_FFFF});
        send_word({TYPE_DATA, 27'h7FF_FFFF});
        send_word({TYPE_DATA, 27'h000_0000});
        send_word({TYPE_TTAG, 27'h7FF_FFFF});
        send_word({TYPE_ERR, 27'h000_0000});
        send_word({TYPE_TDC_HDR, 27'h155_5555});
        send_word({TYPE_TDC_TRL, 27'h2AA_AAAA});
        send_word({TYPE_FILLER, 27'h7FF_FFFF});
        send_word(32'hFFFF_FFFF);
        // Largest trailer count, then a matching one.
        send_word({TYPE_GTRL, 8'hFF, 14'h3FFF, 5'h1F});
        send_word({TYPE_GTRL, 8'h00, 14'd14, 5'h00});
        // Second header already matches its table entry.
        send_word({TYPE_GHDR, 27'h000_0000});
        send_word({TYPE_DATA, 27'h123_4567});
        send_word({TYPE_GTRL, 8'h00, 14'd0, 5'h00});
        // Event start on a word that causes nothing still clears the counts.
        start_pending = 1'b1;
        send_word({TYPE_TTAG, 27'h000_0001});
        send_word({TYPE_GTRL, 8'h5A, 14'd10, 5'h0A});
        send_raw(32'h0000_0000, 1'b1);
        drain();
        // No swap, no correction, all-ones table.
        set_config(1'b0, 1'b0, '1, '1);
        start_pending = 1'b1;
        send_word({TYPE_GHDR, 27'h000_0003});
        send_word({TYPE_DATA, 27'h0AB_CDEF});
        send_word({TYPE_GTRL, 8'h00, 14'd11, 5'h00});
        send_raw(32'hFFFF_FFFF, 1'b1);

        // Random events under a series of register settings.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       set_config(1'b0, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
                1:       set_config(1'b1, 1'b0, '1, '1);
                2:       set_config(1'b0, 1'b1, '1, '1);
                3:       set_config(1'b1, 1'b1, '0, '0);
                4:       set_config(1'b1, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
                default: set_config(1'b0, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            phase_end = items_sent + ITEM_TARGET / PHASES;
            pause_at  = items_sent + $urandom_range(40, 200);
            paused    = 1'b0;
            while (items_sent < phase_end) begin
                send_event();
                if (!paused && items_sent >= pause_at) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
